/* rtl/core/ths_pkg.sv */
// Package: types, constants and sizes for the handshake negotiator.
package ths_pkg;

  localparam int MaxSuitesDef = 8;
  localparam int MaxChainDef  = 8;
  localparam int MaxRootsDef  = 8;

  localparam logic [15:0] SuiteAes128 = 16'h1301;
  localparam logic [15:0] SuiteAes256 = 16'h1302;
  localparam logic [15:0] SuiteChacha = 16'h1303;

  typedef enum logic [2:0] {
    CMD_ADVANCE = 3'd0,
    CMD_SERVER  = 3'd1,
    CMD_CLIENT  = 3'd2,
    CMD_CHAIN   = 3'd3,
    CMD_ROOT    = 3'd4,
    CMD_RESTART = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    PH_INIT         = 3'd0,
    PH_HELLO        = 3'd1,
    PH_SERVER_HELLO = 3'd2,
    PH_CERT_OK      = 3'd3,
    PH_ESTABLISHED  = 3'd4,
    PH_FAILED       = 3'd5
  } phase_t;

  // Memory identifiers for the search unit's read port.
  typedef enum logic [2:0] {
    MEM_SERVER = 3'd0,
    MEM_CLIENT = 3'd1,
    MEM_CSUBJ  = 3'd2,
    MEM_CISS   = 3'd3,
    MEM_ROOT   = 3'd4
  } mem_sel_t;

  typedef enum logic [3:0] {
    SR_IDLE,
    SR_SRV_RD,
    SR_SRV_CHK,
    SR_CLI_RD,
    SR_CLI_CHK,
    SR_ISS_RD,
    SR_SUB_RD,
    SR_LINK_CHK,
    SR_TOP_RD,
    SR_FIRST_RD,
    SR_ROOT_RD,
    SR_ROOT_CHK,
    SR_DONE
  } srch_state_t;

  typedef struct packed {
    logic start_suite;
    logic start_chain;
  } srch_req_t;

  typedef struct packed {
    logic        done;
    logic        ok;
    logic [15:0] suite;
  } srch_rsp_t;

  function automatic logic is_v13(input logic [15:0] s);
    return (s == SuiteAes128) || (s == SuiteAes256) || (s == SuiteChacha);
  endfunction

endpackage

/* rtl/core/tls_handshake_negotiator.sv */
// Top level: handshake phase control, list counts and result register.
// Loads, restart and simple advances: phase, counts and the result are registered on accept.
// Suite search walks S server entries against C client entries; the chain check
// walks N certificates and R roots. One read port on the entry memories serves
// both searches. One item at a time.
// Synchronous active-low reset clears phase, suite, counts and host id.
module tls_handshake_negotiator #(
  parameter int MAX_SUITES = ths_pkg::MaxSuitesDef,
  parameter int MAX_CHAIN  = ths_pkg::MaxChainDef,
  parameter int MAX_ROOTS  = ths_pkg::MaxRootsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [15:0] in_suite_code,
  input  logic [63:0] in_cert_subject,
  input  logic [63:0] in_cert_issuer,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_phase,
  output logic [15:0] out_agreed_suite,
  output logic        out_load_dropped
);

  localparam int M1 = (MAX_SUITES > MAX_CHAIN) ? MAX_SUITES : MAX_CHAIN;
  localparam int MX = (M1 > MAX_ROOTS) ? M1 : MAX_ROOTS;
  localparam int AW = (MX > 1) ? $clog2(MX) : 1;

  logic [63:0] host_r;
  ths_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] suite_r, suite_nxt;
  logic [AW:0] srv_cnt_r, cli_cnt_r, chain_cnt_r, root_cnt_r;
  logic [AW:0] srv_cnt_nxt, cli_cnt_nxt, chain_cnt_nxt, root_cnt_nxt;
  logic        busy_r, busy_nxt, drop, wr_en, accept, finish;
  logic        out_valid_r, out_valid_nxt, drop_r, drop_nxt;
  logic [AW-1:0] wr_addr;
  ths_pkg::cmd_t cmd;
  ths_pkg::srch_req_t req;
  ths_pkg::srch_rsp_t rsp;
  ths_pkg::mem_sel_t rd_sel;
  logic [AW-1:0] rd_addr;
  logic [63:0] rd_data;

  assign cmd = ths_pkg::cmd_t'(in_cmd);
  assign in_stall = busy_r || out_valid_r;
  assign accept = in_valid && !in_stall;
  assign req.start_suite = accept && cmd == ths_pkg::CMD_ADVANCE
                           && phase_r == ths_pkg::PH_HELLO;
  assign req.start_chain = accept && cmd == ths_pkg::CMD_ADVANCE
                           && phase_r == ths_pkg::PH_SERVER_HELLO;
  assign finish = busy_r && rsp.done;

  always_comb begin
    drop = 1'b0;
    wr_en = 1'b0;
    wr_addr = '0;
    srv_cnt_nxt = srv_cnt_r;
    cli_cnt_nxt = cli_cnt_r;
    chain_cnt_nxt = chain_cnt_r;
    root_cnt_nxt = root_cnt_r;
    phase_nxt = phase_r;
    suite_nxt = suite_r;
    busy_nxt = busy_r;
    out_valid_nxt = out_valid_r && out_stall;
    drop_nxt = drop_r;
    if (accept) begin
      drop_nxt = 1'b0;
      out_valid_nxt = 1'b1;
      case (cmd)
        ths_pkg::CMD_ADVANCE: begin
          case (phase_r)
            ths_pkg::PH_INIT:    phase_nxt = ths_pkg::PH_HELLO;
            ths_pkg::PH_CERT_OK: phase_nxt = ths_pkg::PH_ESTABLISHED;
            ths_pkg::PH_HELLO, ths_pkg::PH_SERVER_HELLO: begin
              busy_nxt = 1'b1;
              out_valid_nxt = 1'b0;
            end
            default: ;
          endcase
        end
        ths_pkg::CMD_SERVER: begin
          if (srv_cnt_r < (AW+1)'(MAX_SUITES)) begin
            wr_en = 1'b1; wr_addr = srv_cnt_r[AW-1:0];
            srv_cnt_nxt = srv_cnt_r + 1'b1;
          end else drop = 1'b1;
        end
        ths_pkg::CMD_CLIENT: begin
          if (cli_cnt_r < (AW+1)'(MAX_SUITES)) begin
            wr_en = 1'b1; wr_addr = cli_cnt_r[AW-1:0];
            cli_cnt_nxt = cli_cnt_r + 1'b1;
          end else drop = 1'b1;
        end
        ths_pkg::CMD_CHAIN: begin
          if (chain_cnt_r < (AW+1)'(MAX_CHAIN)) begin
            wr_en = 1'b1; wr_addr = chain_cnt_r[AW-1:0];
            chain_cnt_nxt = chain_cnt_r + 1'b1;
          end else drop = 1'b1;
        end
        ths_pkg::CMD_ROOT: begin
          if (root_cnt_r < (AW+1)'(MAX_ROOTS)) begin
            wr_en = 1'b1; wr_addr = root_cnt_r[AW-1:0];
            root_cnt_nxt = root_cnt_r + 1'b1;
          end else drop = 1'b1;
        end
        ths_pkg::CMD_RESTART: begin
          phase_nxt = ths_pkg::PH_INIT;
          suite_nxt = '0;
        end
        default: ;
      endcase
      drop_nxt = drop;
    end
    if (finish) begin
      busy_nxt = 1'b0;
      out_valid_nxt = 1'b1;
      if (!rsp.ok) begin
        phase_nxt = ths_pkg::PH_FAILED;
      end else if (phase_r == ths_pkg::PH_HELLO) begin
        phase_nxt = ths_pkg::PH_SERVER_HELLO;
        suite_nxt = rsp.suite;
      end else begin
        phase_nxt = ths_pkg::PH_CERT_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host_r      <= '0;
      phase_r     <= ths_pkg::PH_INIT;
      suite_r     <= '0;
      srv_cnt_r   <= '0;
      cli_cnt_r   <= '0;
      chain_cnt_r <= '0;
      root_cnt_r  <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) host_r <= cfg_wdata;
      phase_r     <= phase_nxt;
      suite_r     <= suite_nxt;
      srv_cnt_r   <= srv_cnt_nxt;
      cli_cnt_r   <= cli_cnt_nxt;
      chain_cnt_r <= chain_cnt_nxt;
      root_cnt_r  <= root_cnt_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    drop_r <= drop_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_phase        = phase_r;
  assign out_agreed_suite = suite_r;
  assign out_load_dropped = drop_r;

  ths_store #(
    .MAX_SUITES(MAX_SUITES), .MAX_CHAIN(MAX_CHAIN), .MAX_ROOTS(MAX_ROOTS), .AW(AW)
  ) u_store (
    .clk(clk), .wr_en(wr_en), .wr_cmd(cmd), .wr_addr(wr_addr),
    .wr_suite(in_suite_code), .wr_subj(in_cert_subject), .wr_iss(in_cert_issuer),
    .rd_sel(rd_sel), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  ths_search #(.AW(AW)) u_search (
    .clk(clk), .rst_n(rst_n), .req(req),
    .srv_cnt(srv_cnt_r), .cli_cnt(cli_cnt_r), .chain_cnt(chain_cnt_r),
    .root_cnt(root_cnt_r), .host_id(host_r), .rd_data(rd_data),
    .rd_sel(rd_sel), .rd_addr(rd_addr), .rsp(rsp)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !accept) else $error("item taken during search");
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    srv_cnt_r <= (AW+1)'(MAX_SUITES) && chain_cnt_r <= (AW+1)'(MAX_CHAIN))
    else $error("list count overflow");
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_valid) else $error("search result not presented");
  a_drop_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_load_dropped) |-> !busy_r) else $error("drop flag during search");

endmodule

/* rtl/core/ths_store.sv */
// Entry memories for suites, chain certificates and trust roots.
module ths_store #(
  parameter int MAX_SUITES = ths_pkg::MaxSuitesDef,
  parameter int MAX_CHAIN  = ths_pkg::MaxChainDef,
  parameter int MAX_ROOTS  = ths_pkg::MaxRootsDef,
  parameter int AW         = 6
) (
  input  logic                clk,
  input  logic                wr_en,
  input  ths_pkg::cmd_t       wr_cmd,
  input  logic [AW-1:0]       wr_addr,
  input  logic [15:0]         wr_suite,
  input  logic [63:0]         wr_subj,
  input  logic [63:0]         wr_iss,
  input  ths_pkg::mem_sel_t   rd_sel,
  input  logic [AW-1:0]       rd_addr,
  output logic [63:0]         rd_data
);

  logic [15:0] srv_mem  [MAX_SUITES];
  logic [15:0] cli_mem  [MAX_SUITES];
  logic [63:0] subj_mem [MAX_CHAIN];
  logic [63:0] iss_mem  [MAX_CHAIN];
  logic [63:0] root_mem [MAX_ROOTS];
  logic [15:0] srv_q, cli_q;
  logic [63:0] subj_q, iss_q, root_q;
  ths_pkg::mem_sel_t sel_r;

  localparam int SAW = (MAX_SUITES > 1) ? $clog2(MAX_SUITES) : 1;
  localparam int CAW = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
  localparam int RAW = (MAX_ROOTS > 1) ? $clog2(MAX_ROOTS) : 1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (wr_cmd)
        ths_pkg::CMD_SERVER: srv_mem[wr_addr[SAW-1:0]] <= wr_suite;
        ths_pkg::CMD_CLIENT: cli_mem[wr_addr[SAW-1:0]] <= wr_suite;
        ths_pkg::CMD_CHAIN: begin
          subj_mem[wr_addr[CAW-1:0]] <= wr_subj;
          iss_mem[wr_addr[CAW-1:0]]  <= wr_iss;
        end
        ths_pkg::CMD_ROOT: root_mem[wr_addr[RAW-1:0]] <= wr_subj;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    srv_q  <= srv_mem[rd_addr[SAW-1:0]];
    cli_q  <= cli_mem[rd_addr[SAW-1:0]];
    subj_q <= subj_mem[rd_addr[CAW-1:0]];
    iss_q  <= iss_mem[rd_addr[CAW-1:0]];
    root_q <= root_mem[rd_addr[RAW-1:0]];
    sel_r  <= rd_sel;
  end

  always_comb begin
    unique case (sel_r)
      ths_pkg::MEM_SERVER: rd_data = {48'd0, srv_q};
      ths_pkg::MEM_CLIENT: rd_data = {48'd0, cli_q};
      ths_pkg::MEM_CSUBJ:  rd_data = subj_q;
      ths_pkg::MEM_CISS:   rd_data = iss_q;
      ths_pkg::MEM_ROOT:   rd_data = root_q;
      default:             rd_data = '0;
    endcase
  end

endmodule

/* rtl/core/ths_search.sv */
// Sequential suite search and chain walk over the entry memories.
module ths_search #(
  parameter int AW = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ths_pkg::srch_req_t req,
  input  logic [AW:0]        srv_cnt,
  input  logic [AW:0]        cli_cnt,
  input  logic [AW:0]        chain_cnt,
  input  logic [AW:0]        root_cnt,
  input  logic [63:0]        host_id,
  input  logic [63:0]        rd_data,
  output ths_pkg::mem_sel_t  rd_sel,
  output logic [AW-1:0]      rd_addr,
  output ths_pkg::srch_rsp_t rsp
);

  ths_pkg::srch_state_t st_r, st_nxt;
  logic [AW:0]  a_r, a_nxt, b_r, b_nxt;
  logic [63:0]  hold_r, hold_nxt;
  logic         ok_r, ok_nxt, first_ok_r, first_ok_nxt;
  logic [15:0]  suite_r, suite_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ths_pkg::SR_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    hold_r     <= hold_nxt;
    ok_r       <= ok_nxt;
    first_ok_r <= first_ok_nxt;
    suite_r    <= suite_nxt;
  end

  // next state and datapath
  always_comb begin
    st_nxt       = st_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    hold_nxt     = hold_r;
    ok_nxt       = ok_r;
    first_ok_nxt = first_ok_r;
    suite_nxt    = suite_r;
    unique case (st_r)
      ths_pkg::SR_IDLE: begin
        a_nxt = '0;
        b_nxt = '0;
        ok_nxt = 1'b0;
        suite_nxt = '0;
        if (req.start_suite) begin
          st_nxt = (srv_cnt == '0) ? ths_pkg::SR_DONE : ths_pkg::SR_SRV_RD;
        end else if (req.start_chain) begin
          if (chain_cnt == '0) begin
            st_nxt = ths_pkg::SR_DONE;
          end else if (chain_cnt == (AW+1)'(1)) begin
            st_nxt = ths_pkg::SR_TOP_RD;
          end else begin
            st_nxt = ths_pkg::SR_ISS_RD;
          end
        end
      end
      ths_pkg::SR_SRV_RD: st_nxt = ths_pkg::SR_SRV_CHK;
      ths_pkg::SR_SRV_CHK: begin
        hold_nxt = rd_data;
        b_nxt = '0;
        if (ths_pkg::is_v13(rd_data[15:0]) && cli_cnt != '0) begin
          st_nxt = ths_pkg::SR_CLI_RD;
        end else if (a_r + 1'b1 < srv_cnt) begin
          a_nxt = a_r + 1'b1;
          st_nxt = ths_pkg::SR_SRV_RD;
        end else begin
          st_nxt = ths_pkg::SR_DONE;
        end
      end
      ths_pkg::SR_CLI_RD: st_nxt = ths_pkg::SR_CLI_CHK;
      ths_pkg::SR_CLI_CHK: begin
        if (rd_data[15:0] == hold_r[15:0]) begin
          ok_nxt = 1'b1;
          suite_nxt = hold_r[15:0];
          st_nxt = ths_pkg::SR_DONE;
        end else if (b_r + 1'b1 < cli_cnt) begin
          b_nxt = b_r + 1'b1;
          st_nxt = ths_pkg::SR_CLI_RD;
        end else if (a_r + 1'b1 < srv_cnt) begin
          a_nxt = a_r + 1'b1;
          st_nxt = ths_pkg::SR_SRV_RD;
        end else begin
          st_nxt = ths_pkg::SR_DONE;
        end
      end
      // link check: issuer[a] against subject[a+1]
      ths_pkg::SR_ISS_RD: st_nxt = ths_pkg::SR_SUB_RD;
      ths_pkg::SR_SUB_RD: begin
        hold_nxt = rd_data;
        st_nxt = ths_pkg::SR_LINK_CHK;
      end
      ths_pkg::SR_LINK_CHK: begin
        if (rd_data != hold_r) begin
          st_nxt = ths_pkg::SR_DONE;
        end else if (a_r + (AW+1)'(2) < chain_cnt) begin
          a_nxt = a_r + 1'b1;
          st_nxt = ths_pkg::SR_ISS_RD;
        end else begin
          st_nxt = ths_pkg::SR_TOP_RD;
        end
      end
      // last subject arrives here, first subject in SR_FIRST_RD
      ths_pkg::SR_TOP_RD: begin
        hold_nxt = rd_data;
        st_nxt = ths_pkg::SR_FIRST_RD;
      end
      ths_pkg::SR_FIRST_RD: begin
        first_ok_nxt = (rd_data == host_id);
        b_nxt = '0;
        st_nxt = ths_pkg::SR_ROOT_RD;
      end
      ths_pkg::SR_ROOT_RD: begin
        st_nxt = (root_cnt == '0) ? ths_pkg::SR_DONE : ths_pkg::SR_ROOT_CHK;
      end
      ths_pkg::SR_ROOT_CHK: begin
        if (rd_data == hold_r) begin
          ok_nxt = first_ok_r;
          st_nxt = ths_pkg::SR_DONE;
        end else if (b_r + 1'b1 < root_cnt) begin
          b_nxt = b_r + 1'b1;
          st_nxt = ths_pkg::SR_ROOT_RD;
        end else begin
          st_nxt = ths_pkg::SR_DONE;
        end
      end
      ths_pkg::SR_DONE: st_nxt = ths_pkg::SR_IDLE;
      default: st_nxt = ths_pkg::SR_IDLE;
    endcase
  end

  // read port drive
  always_comb begin
    rd_sel  = ths_pkg::MEM_SERVER;
    rd_addr = a_r[AW-1:0];
    unique case (st_r)
      ths_pkg::SR_IDLE: begin
        rd_sel  = req.start_chain ? ths_pkg::MEM_CISS : ths_pkg::MEM_SERVER;
        rd_addr = '0;
        if (req.start_chain && chain_cnt == (AW+1)'(1)) rd_sel = ths_pkg::MEM_CSUBJ;
      end
      ths_pkg::SR_SRV_CHK: begin
        if (ths_pkg::is_v13(rd_data[15:0]) && cli_cnt != '0) begin
          rd_sel = ths_pkg::MEM_CLIENT;
          rd_addr = '0;
        end else begin
          rd_addr = AW'(a_r + 1'b1);
        end
      end
      ths_pkg::SR_CLI_RD: begin
        rd_sel = ths_pkg::MEM_CLIENT;
        rd_addr = b_r[AW-1:0];
      end
      ths_pkg::SR_CLI_CHK: begin
        if (b_r + 1'b1 < cli_cnt) begin
          rd_sel = ths_pkg::MEM_CLIENT;
          rd_addr = AW'(b_r + 1'b1);
        end else begin
          rd_addr = AW'(a_r + 1'b1);
        end
      end
      ths_pkg::SR_ISS_RD: begin
        rd_sel = ths_pkg::MEM_CSUBJ;
        rd_addr = AW'(a_r + 1'b1);
      end
      ths_pkg::SR_SUB_RD: begin
        rd_sel = ths_pkg::MEM_CISS;
        rd_addr = a_r[AW-1:0];
      end
      ths_pkg::SR_LINK_CHK: begin
        rd_sel = ths_pkg::MEM_CISS;
        rd_addr = AW'(a_r + 1'b1);
        if (!(a_r + (AW+1)'(2) < chain_cnt)) begin
          rd_sel = ths_pkg::MEM_CSUBJ;
          rd_addr = AW'(chain_cnt - 1'b1);
        end
      end
      ths_pkg::SR_TOP_RD: begin
        rd_sel = ths_pkg::MEM_CSUBJ;
        rd_addr = '0;
      end
      ths_pkg::SR_FIRST_RD: begin
        rd_sel = ths_pkg::MEM_ROOT;
        rd_addr = '0;
      end
      ths_pkg::SR_ROOT_RD: begin
        rd_sel = ths_pkg::MEM_ROOT;
        rd_addr = b_r[AW-1:0];
      end
      ths_pkg::SR_ROOT_CHK: begin
        rd_sel = ths_pkg::MEM_ROOT;
        rd_addr = AW'(b_r + 1'b1);
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp.done  = (st_r == ths_pkg::SR_DONE);
    rsp.ok    = ok_r;
    rsp.suite = suite_r;
  end

  a_ok_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ths_pkg::SR_DONE && ok_r && suite_r != '0) |-> ths_pkg::is_v13(suite_r))
    else $error("chosen suite not a 1.3 code");
  a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ths_pkg::SR_DONE) |=> (st_r == ths_pkg::SR_IDLE))
    else $error("search did not return to idle");
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ths_pkg::SR_CLI_CHK) |-> (b_r < cli_cnt && a_r < srv_cnt))
    else $error("search index out of range");

endmodule
